FILE: design/kwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way merge package
// Shared field widths, register reset value and the command/status bundles
// passed between the merge controller and its datapath.
// ----------------------------------------------------------------------------
package kwm_pkg;

   // Fixed widths of the channel fields
   localparam int ID_BITS      = 4;
   localparam int IN_VAL_BITS  = 32;
   localparam int OUT_VAL_BITS = 32;
   localparam int CFG_BITS     = 5;

   // active_lists after reset
   localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 5'd16;

   // Controller -> datapath
   typedef struct packed {
      logic load_item;   // input beat taken this cycle
      logic scan_issue;  // read head entry at scan pointer, advance pointer
      logic emit;        // load result register, release or clear heads
   } kwm_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic scan_last;   // scan pointer is on the last active list
      logic all_ready;   // every active list holds a head or is exhausted
      logic out_free;    // result register can take a new beat
   } kwm_stat_type;

endpackage

FILE: design/k_way_sorted_merge_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way sorted merge core
// Merges up to MAX_LISTS ascending signed lists into one ascending stream.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel: one beat carries the next value of list req_list_id, or
//    that list's end mark (req_list_end). Beats for a list whose head is
//    already held, that is exhausted, or that is not active are dropped.
//  - rsp_* channel: the smallest held head and its list once every active
//    list holds a head or is exhausted (ties go to the lowest list); that
//    list must be refilled next. rsp_done_res marks the end of the merge,
//    after which all lists are cleared for the next one.
//  - csr_* channel: writes active_lists; write only while idle.
//  - Each input beat passes through accept, a head scan of every active list
//    in turn through the single read port of the head memory, then drain and
//    decide. A result, if any, is loaded into the output register by the
//    decide step, which waits while a stalled receiver holds that register.
//  - A new beat is accepted while a result waits in the output register; a
//    stalled receiver holds the block only when the next result is ready.
//  - Reset clears all flags at once and sets active_lists to 16; no
//    clearing pass is needed.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core #(
   parameter int MAX_LISTS  = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [kwm_pkg::ID_BITS-1:0]             req_list_id,
   input  logic signed [kwm_pkg::IN_VAL_BITS-1:0]  req_value,
   input  logic                                    req_list_end,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [kwm_pkg::OUT_VAL_BITS-1:0] rsp_merged_value,
   output logic [kwm_pkg::ID_BITS-1:0]             rsp_source_list,
   output logic                                    rsp_done_res,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [kwm_pkg::CFG_BITS-1:0]            csr_active_lists
);
   import kwm_pkg::*;

   kwm_cmd_type  cmd;
   kwm_stat_type stat;

   // register write always taken
   assign csr_ready = 1'b1;

   kwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kwm_datapath #(
      .MAX_LISTS  (MAX_LISTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_list_id      (req_list_id),
      .req_value        (req_value),
      .req_list_end     (req_list_end),
      .csr_valid        (csr_valid),
      .csr_active_lists (csr_active_lists),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_merged_value (rsp_merged_value),
      .rsp_source_list  (rsp_source_list),
      .rsp_done_res     (rsp_done_res)
   );

endmodule

FILE: design/kwm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way merge controller
// Sequences one input beat: accept and update, scan of all active heads,
// drain, then the decision; an emit waits until the result register is free.
// ----------------------------------------------------------------------------
module kwm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kwm_pkg::kwm_stat_type stat,
   output kwm_pkg::kwm_cmd_type  cmd
);
   import kwm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.load_item  = 1'b0;
      cmd.scan_issue = 1'b0;
      cmd.emit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last read entry folds into the accumulators
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!stat.all_ready) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/kwm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-way merge datapath
// Head memory, valid and exhausted flags, sequential minimum scan and the
// result register.
// ----------------------------------------------------------------------------
module kwm_datapath #(
   parameter int MAX_LISTS  = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  kwm_pkg::kwm_cmd_type                   cmd,
   output kwm_pkg::kwm_stat_type                  stat,
   input  logic [kwm_pkg::ID_BITS-1:0]            req_list_id,
   input  logic signed [kwm_pkg::IN_VAL_BITS-1:0] req_value,
   input  logic                                   req_list_end,
   input  logic                                   csr_valid,
   input  logic [kwm_pkg::CFG_BITS-1:0]           csr_active_lists,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [kwm_pkg::OUT_VAL_BITS-1:0] rsp_merged_value,
   output logic [kwm_pkg::ID_BITS-1:0]            rsp_source_list,
   output logic                                   rsp_done_res
);
   import kwm_pkg::*;

   localparam int LIST_BITS = $clog2(MAX_LISTS);
   localparam int CNT_BITS  = $clog2(MAX_LISTS + 1);

   // configuration register
   logic [CFG_BITS-1:0] active_ff;

   // head store and flags
   logic [VALUE_BITS-1:0] head_value_ff [MAX_LISTS];
   logic [MAX_LISTS-1:0]  head_valid_ff, head_valid_in;
   logic [MAX_LISTS-1:0]  list_exh_ff, list_exh_in;

   // scan pointer and read stage
   logic [LIST_BITS-1:0]  scan_ptr_ff, scan_ptr_in;
   logic                  p_live_ff;
   logic [LIST_BITS-1:0]  p_idx_ff;
   logic                  p_valid_ff;
   logic                  p_exh_ff;
   logic [VALUE_BITS-1:0] rd_value_ff;

   // accumulators
   logic                  any_head_ff, any_head_in;
   logic                  all_ready_ff, all_ready_in;
   logic [LIST_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [VALUE_BITS-1:0] best_val_ff, best_val_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_VAL_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [ID_BITS-1:0]      rsp_src_ff, rsp_src_in;
   logic                    rsp_done_ff, rsp_done_in;

   logic [CNT_BITS-1:0]   count;
   logic [31:0]           id_wide;
   logic [LIST_BITS-1:0]  id_idx;
   logic                  id_live;
   logic [63:0]           in_wide;
   logic [VALUE_BITS-1:0] in_val;
   logic [95:0]           out_wide;
   logic [31:0]           src_wide;
   logic                  head_write;

   // Effective list count: zero acts as one, clipped to the store depth
   always_comb begin
      if (active_ff == '0) begin
         count = CNT_BITS'(1);
      end else if (32'(active_ff) > MAX_LISTS) begin
         count = CNT_BITS'(MAX_LISTS);
      end else begin
         count = CNT_BITS'(active_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_valid) begin
         active_ff <= csr_active_lists;
      end
   end

   // Incoming beat: index, range check, width fit
   assign id_wide = 32'(req_list_id);
   assign id_idx  = id_wide[LIST_BITS-1:0];
   assign id_live = (id_wide < 32'(count)) && !head_valid_ff[id_idx] && !list_exh_ff[id_idx];
   assign in_wide = {{32{req_value[31]}}, req_value};
   assign in_val  = in_wide[VALUE_BITS-1:0];
   assign head_write = cmd.load_item && id_live && !req_list_end;

   // Head memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (head_write) begin
         head_value_ff[id_idx] <= in_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         rd_value_ff <= head_value_ff[scan_ptr_ff];
      end
   end

   // Flag updates: fill on a beat, release or clear on emit
   always_comb begin
      head_valid_in = head_valid_ff;
      list_exh_in   = list_exh_ff;
      if (cmd.load_item && id_live) begin
         if (req_list_end) begin
            list_exh_in[id_idx] = 1'b1;
         end else begin
            head_valid_in[id_idx] = 1'b1;
         end
      end
      if (cmd.emit) begin
         if (any_head_ff) begin
            head_valid_in[best_idx_ff] = 1'b0;
         end else begin
            head_valid_in = '0;
            list_exh_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         list_exh_ff   <= '0;
      end else begin
         head_valid_ff <= head_valid_in;
         list_exh_ff   <= list_exh_in;
      end
   end

   // Scan pointer
   always_comb begin
      scan_ptr_in = scan_ptr_ff;
      if (cmd.load_item) begin
         scan_ptr_in = '0;
      end else if (cmd.scan_issue) begin
         scan_ptr_in = scan_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff <= '0;
         p_live_ff   <= 1'b0;
      end else begin
         scan_ptr_ff <= scan_ptr_in;
         p_live_ff   <= cmd.scan_issue;
      end
   end

   // flags travel alongside the memory read
   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         p_idx_ff   <= scan_ptr_ff;
         p_valid_ff <= head_valid_ff[scan_ptr_ff];
         p_exh_ff   <= list_exh_ff[scan_ptr_ff];
      end
   end

   // Running minimum; strict less keeps the lowest index on a tie
   always_comb begin
      any_head_in  = any_head_ff;
      all_ready_in = all_ready_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      if (cmd.load_item) begin
         any_head_in  = 1'b0;
         all_ready_in = 1'b1;
      end else if (p_live_ff) begin
         if (p_valid_ff) begin
            if (!any_head_ff || ($signed(rd_value_ff) < $signed(best_val_ff))) begin
               best_idx_in = p_idx_ff;
               best_val_in = rd_value_ff;
            end
            any_head_in = 1'b1;
         end else if (!p_exh_ff) begin
            all_ready_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_head_ff  <= 1'b0;
         all_ready_ff <= 1'b0;
      end else begin
         any_head_ff  <= any_head_in;
         all_ready_ff <= all_ready_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
   end

   // Result register
   assign out_wide = {{(96 - VALUE_BITS){1'b0}}, best_val_ff};
   assign src_wide = 32'(best_idx_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_done_in  = rsp_done_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (any_head_ff) begin
            rsp_value_in = out_wide[OUT_VAL_BITS-1:0];
            rsp_src_in   = src_wide[ID_BITS-1:0];
            rsp_done_in  = 1'b0;
         end else begin
            rsp_value_in = '0;
            rsp_src_in   = '0;
            rsp_done_in  = 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_source_list  = rsp_src_ff;
   assign rsp_done_res     = rsp_done_ff;

   // Status back to the controller
   assign stat.scan_last = (32'(scan_ptr_ff) + 32'd1) == 32'(count);
   assign stat.all_ready = all_ready_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // Checks
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_emit_valid_head: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && any_head_ff) |-> head_valid_ff[best_idx_ff])
      else $error("emitted list holds no head");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !any_head_ff) |=> (head_valid_ff == '0 && list_exh_ff == '0))
      else $error("flags survive a done result");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> (32'(scan_ptr_ff) < 32'(count)))
      else $error("scan beyond active lists");

endmodule
